// ===== hdl/smprc_pkg.sv =====
// ----------------------------------------------------------------------------
// smprc_pkg
// Types, constants and register indexes for the SIP method packet-rate counter.
// ----------------------------------------------------------------------------
`default_nettype none

package smprc_pkg;

   localparam int DEFAULT_COUNT_WIDTH      = 32;
   localparam int DEFAULT_MAX_METHOD_BYTES = 8;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USE_TCP          = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_PORT       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_IP_FILTER = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEST_IP_FILTER   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METHOD_TEXT      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METHOD_LENGTH    = 3'd5;

   localparam logic [15:0] RESET_MATCH_PORT    = 16'd5060;
   localparam logic [63:0] RESET_METHOD_TEXT   = 64'h494E_5649_5445_0000;
   localparam logic [3:0]  RESET_METHOD_LENGTH = 4'd6;

   localparam logic [7:0]  BROADCAST_BYTE  = 8'hFF;
   localparam logic [7:0]  ETHERTYPE_HIGH  = 8'h08;
   localparam logic [7:0]  ETHERTYPE_LOW   = 8'h00;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;

   localparam logic [15:0] OFS_DEST_LAST   = 16'd5;
   localparam logic [15:0] OFS_TYPE_HIGH   = 16'd12;
   localparam logic [15:0] OFS_TYPE_LOW    = 16'd13;
   localparam logic [15:0] OFS_PROTOCOL    = 16'd23;
   localparam logic [15:0] OFS_SRC_IP      = 16'd26;
   localparam logic [15:0] OFS_DST_IP      = 16'd30;
   localparam logic [15:0] OFS_SRC_PORT    = 16'd34;
   localparam logic [15:0] OFS_DST_PORT    = 16'd36;
   localparam logic [15:0] OFS_UDP_PAYLOAD = 16'd42;
   localparam logic [15:0] OFS_TCP_PAYLOAD = 16'd54;
   localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic {
      REPORT_VERDICT = 1'b0,
      REPORT_TICK    = 1'b1
   } report_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      report_type  report_kind;
      logic        frame_counted;
      logic [31:0] rate;
      logic [31:0] peak_rate;
      logic [31:0] total_count;
   } rsp_type;

   typedef struct packed {
      logic        use_tcp;
      logic [15:0] match_port;
      logic [31:0] source_ip_filter;
      logic [31:0] dest_ip_filter;
      logic [63:0] method_text;
      logic [3:0]  method_length;
   } cfg_type;

   typedef struct packed {
      report_type kind;
      logic       counted;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type data;
   } queue_port_type;

endpackage

`default_nettype wire

// ===== hdl/smprc_parser.sv =====
// ----------------------------------------------------------------------------
// smprc_parser
// Front end: walks frame bytes at fixed header offsets and issues one verdict
// event per frame and one event per tick into the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smprc_parser
   import smprc_pkg::*;
#(
   parameter int MAX_METHOD_BYTES = DEFAULT_MAX_METHOD_BYTES
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cfg_type        cfg,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_payload,
   input  wire logic           queue_full,
   output queue_port_type      push
);

   localparam logic [3:0] MAX_LEN = 4'(MAX_METHOD_BYTES);

   logic [15:0] byte_index_ff, byte_index_in;
   logic        rejected_ff, rejected_in;
   logic        dest_ones_ff, dest_ones_in;
   logic [7:0]  port_high_ff, port_high_in;
   logic        port_hit_ff, port_hit_in;
   logic        method_ok_ff, method_ok_in;

   logic [15:0] idx;
   logic [7:0]  b;
   logic [15:0] start;
   logic [3:0]  len;
   logic [15:0] meth_end;
   logic [15:0] meth_off;
   logic [15:0] ip_off;
   logic        rej, ones, hit, mok;
   logic [7:0]  phigh;
   logic [7:0]  method_bytes [8];
   logic [7:0]  src_bytes [4];
   logic [7:0]  dst_bytes [4];
   logic        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         method_bytes[k] = cfg.method_text[63-8*k -: 8];
      end
      for (int k = 0; k < 4; k++) begin
         src_bytes[k] = cfg.source_ip_filter[31-8*k -: 8];
         dst_bytes[k] = cfg.dest_ip_filter[31-8*k -: 8];
      end
   end

   always_comb begin
      idx      = byte_index_ff;
      b        = req_payload.data_byte;
      rej      = rejected_ff;
      ones     = dest_ones_ff;
      phigh    = port_high_ff;
      hit      = port_hit_ff;
      mok      = method_ok_ff;
      start    = cfg.use_tcp ? OFS_TCP_PAYLOAD : OFS_UDP_PAYLOAD;
      len      = (cfg.method_length > MAX_LEN) ? MAX_LEN : cfg.method_length;
      meth_end = start + 16'(len);
      meth_off = idx - start;
      ip_off   = 16'd0;

      if (idx <= OFS_DEST_LAST) begin
         if (b != BROADCAST_BYTE) begin
            ones = 1'b0;
         end
         if (idx == OFS_DEST_LAST && ones) begin
            rej = 1'b1;
         end
      end else if (idx == OFS_TYPE_HIGH) begin
         if (b != ETHERTYPE_HIGH) begin
            rej = 1'b1;
         end
      end else if (idx == OFS_TYPE_LOW) begin
         if (b != ETHERTYPE_LOW) begin
            rej = 1'b1;
         end
      end else if (idx == OFS_PROTOCOL) begin
         if (b != (cfg.use_tcp ? PROTO_TCP : PROTO_UDP)) begin
            rej = 1'b1;
         end
      end else if (idx >= OFS_SRC_IP && idx < OFS_DST_IP) begin
         ip_off = idx - OFS_SRC_IP;
         if (cfg.source_ip_filter != 32'd0 && b != src_bytes[ip_off[1:0]]) begin
            rej = 1'b1;
         end
      end else if (idx >= OFS_DST_IP && idx < OFS_SRC_PORT) begin
         ip_off = idx - OFS_DST_IP;
         if (cfg.dest_ip_filter != 32'd0 && b != dst_bytes[ip_off[1:0]]) begin
            rej = 1'b1;
         end
      end else if (idx == OFS_SRC_PORT || idx == OFS_DST_PORT) begin
         phigh = b;
      end else if (idx == OFS_SRC_PORT + 16'd1 || idx == OFS_DST_PORT + 16'd1) begin
         if ({port_high_ff, b} == cfg.match_port) begin
            hit = 1'b1;
         end
         if (idx == OFS_DST_PORT + 16'd1 && !hit) begin
            rej = 1'b1;
         end
      end else if (idx >= start && idx < meth_end) begin
         if (b != method_bytes[meth_off[2:0]]) begin
            rej = 1'b1;
         end
      end

      if ({1'b0, idx} + 17'd1 == {1'b0, meth_end} && !rej) begin
         mok = 1'b1;
      end

      byte_index_in = byte_index_ff;
      rejected_in   = rejected_ff;
      dest_ones_in  = dest_ones_ff;
      port_high_in  = port_high_ff;
      port_hit_in   = port_hit_ff;
      method_ok_in  = method_ok_ff;

      push.valid        = 1'b0;
      push.data.kind    = REPORT_VERDICT;
      push.data.counted = 1'b0;

      if (accept) begin
         if (req_payload.cmd == CMD_TICK) begin
            push.valid     = 1'b1;
            push.data.kind = REPORT_TICK;
         end else if (req_payload.last_byte) begin
            push.valid        = 1'b1;
            push.data.counted = mok && !rej;
            byte_index_in     = 16'd0;
            rejected_in       = 1'b0;
            dest_ones_in      = 1'b1;
            port_high_in      = 8'd0;
            port_hit_in       = 1'b0;
            method_ok_in      = 1'b0;
         end else begin
            byte_index_in = (idx < INDEX_MAX) ? idx + 16'd1 : idx;
            rejected_in   = rej;
            dest_ones_in  = ones;
            port_high_in  = phigh;
            port_hit_in   = hit;
            method_ok_in  = mok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 16'd0;
         rejected_ff   <= 1'b0;
         dest_ones_ff  <= 1'b1;
         port_high_ff  <= 8'd0;
         port_hit_ff   <= 1'b0;
         method_ok_ff  <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         rejected_ff   <= rejected_in;
         dest_ones_ff  <= dest_ones_in;
         port_high_ff  <= port_high_in;
         port_hit_ff   <= port_hit_in;
         method_ok_ff  <= method_ok_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/smprc_queue.sv =====
// ----------------------------------------------------------------------------
// smprc_queue
// Two-entry event queue between the frame parser and the statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

module smprc_queue
   import smprc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_port_type push,
   output logic                full,
   output queue_port_type      head,
   input  wire logic           pop
);

   event_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push.valid) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/smprc_stats.sv =====
// ----------------------------------------------------------------------------
// smprc_stats
// Back end: keeps the match total, tick snapshot and peak rate, and drives
// the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smprc_stats
   import smprc_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_port_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_payload
);

   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] previous_ff, previous_in;
   logic [COUNT_WIDTH-1:0] highest_ff, highest_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   wrapped;
   logic [COUNT_WIDTH-1:0] rate;

   assign pop         = head.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      wrapped      = (total_ff < previous_ff);
      rate         = wrapped ? total_ff : total_ff - previous_ff;
      total_in     = total_ff;
      previous_in  = previous_ff;
      highest_in   = highest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (pop) begin
         rsp_valid_in         = 1'b1;
         rsp_in.report_kind   = head.data.kind;
         rsp_in.frame_counted = 1'b0;
         rsp_in.rate          = 32'd0;
         rsp_in.peak_rate     = 32'd0;
         rsp_in.total_count   = 32'd0;
         if (head.data.kind == REPORT_TICK) begin
            if (wrapped) begin
               total_in = '0;
            end
            previous_in = total_ff;
            if (rate > highest_ff) begin
               highest_in = rate;
            end
            rsp_in.rate        = 32'(rate);
            rsp_in.peak_rate   = 32'(highest_in);
            rsp_in.total_count = 32'(total_ff);
         end else begin
            rsp_in.frame_counted = head.data.counted;
            if (head.data.counted) begin
               total_in = total_ff + COUNT_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         previous_ff  <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         previous_ff  <= previous_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sip_method_packet_rate_counter.sv =====
// ----------------------------------------------------------------------------
// sip_method_packet_rate_counter
// Counts SIP request frames of one method and reports per-tick rate figures.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the event queue has room: a frame byte
// or a tick. Every frame gives a verdict transaction on its last byte and every
// tick gives a rate report; all other bytes give nothing. The parser checks
// each byte and hands verdicts and ticks through a two-entry queue to the
// statistics unit, so a result passes the queue entry and then the response
// register before it is offered on rsp_valid, and the block keeps one item per
// cycle as long as rsp_ready stays high. The user must write configuration
// through the csr port while the block is idle; the block does not enforce it.
`default_nettype none

module sip_method_packet_rate_counter
   import smprc_pkg::*;
#(
   parameter int COUNT_WIDTH      = DEFAULT_COUNT_WIDTH,
   parameter int MAX_METHOD_BYTES = DEFAULT_MAX_METHOD_BYTES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp_payload,
   input  wire logic                       csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   queue_port_type push;
   queue_port_type head;
   logic           queue_full;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_USE_TCP:          cfg_in.use_tcp          = csr_wdata[0];
            CSR_MATCH_PORT:       cfg_in.match_port       = csr_wdata[15:0];
            CSR_SOURCE_IP_FILTER: cfg_in.source_ip_filter = csr_wdata[31:0];
            CSR_DEST_IP_FILTER:   cfg_in.dest_ip_filter   = csr_wdata[31:0];
            CSR_METHOD_TEXT:      cfg_in.method_text      = csr_wdata;
            CSR_METHOD_LENGTH:    cfg_in.method_length    = csr_wdata[3:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_tcp          <= 1'b0;
         cfg_ff.match_port       <= RESET_MATCH_PORT;
         cfg_ff.source_ip_filter <= 32'd0;
         cfg_ff.dest_ip_filter   <= 32'd0;
         cfg_ff.method_text      <= RESET_METHOD_TEXT;
         cfg_ff.method_length    <= RESET_METHOD_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smprc_parser #(
      .MAX_METHOD_BYTES (MAX_METHOD_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push)
   );

   smprc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   smprc_stats #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_stats (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hdl/smprc_checker.sv =====
// ----------------------------------------------------------------------------
// smprc_checker
// Port-level checks on the response channel of the rate counter.
// ----------------------------------------------------------------------------
`default_nettype none

module smprc_checker
   import smprc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // verdicts carry no rate figures
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.report_kind == REPORT_VERDICT |->
         rsp_payload.rate == 32'd0 && rsp_payload.peak_rate == 32'd0 &&
         rsp_payload.total_count == 32'd0)
      else $error("verdict with rate fields");

   // a tick report never flags a frame and its peak covers its rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.report_kind == REPORT_TICK |->
         !rsp_payload.frame_counted && rsp_payload.peak_rate >= rsp_payload.rate)
      else $error("bad tick report");

endmodule

bind sip_method_packet_rate_counter smprc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
